// ===== hdl/tesf_pkg.sv =====
// shared constants for the trajectory end segment filter
`default_nettype none
package tesf_pkg;

	localparam int LON_W = 17;
	localparam int LAT_W = 15;
	localparam int PRES_W = 15;
	localparam int COS_W = 16;
	localparam int CNT_W = 21;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COS_ANGLE_LIMIT = 1'd1;

	localparam logic [PRES_W-1:0] PRESSURE_LIMIT_RST = 15'd800;
	localparam logic [COS_W-1:0] COS_LIMIT_RST = 16'd0;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam int SHORT_LINE_COUNT = 2;

	localparam int MUL_W = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W = 128;

	localparam int LAT_SAT = 11520;
	localparam int LAT_HALF = 5760;
	localparam int LAT_PRE_SHIFT = 8;
	localparam int RECIP_45 = 372828;
	localparam int RECIP_SHIFT = 24;
	localparam int X_ROUND = 512;
	localparam int X_SHIFT = 10;
	localparam int Y_SHIFT = 5;
	localparam int LIM_SHIFT = 30;

endpackage
`default_nettype wire

// ===== hdl/trajectory_end_segment_filter.sv =====
// trajectory end segment filter: end vertex turn and pressure tests, at most one segment per line
//
// channel  direction  handshake              payload
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in       in         in_valid / in_ready    lon, lat, pressure, vertex_index, last_in_line
// out      out        out_valid / out_ready  seg_start, seg_count
//
// a vertex with no end test goes from dispatch straight to the finish state; each end test
// runs 22 products on one shared 33x33 multiplier, each in capture, multiply and accumulate
// phases, then a decision and a return to the dispatch state
// the third vertex of a line that is also its last runs two end tests
// reset clears config to defaults, the vertex window and all counters
// a waiting result does not block the next word; only a second result stalls
`default_nettype none
module trajectory_end_segment_filter #(
	parameter int INDEX_BITS = 20,
	parameter int COS_TABLE_DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tesf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tesf_pkg::COS_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [tesf_pkg::LON_W-1:0]   lon,
	input  logic signed [tesf_pkg::LAT_W-1:0]   lat,
	input  logic [tesf_pkg::PRES_W-1:0]         pressure,
	input  logic [INDEX_BITS-1:0]               vertex_index,
	input  logic                                last_in_line,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [INDEX_BITS-1:0]               seg_start,
	output logic [tesf_pkg::CNT_W-1:0]          seg_count
);
	import tesf_pkg::*;

	localparam int TAB_W = $clog2(COS_TABLE_DEPTH);

	typedef logic [14:0] cos_tab_t [COS_TABLE_DEPTH];

	function automatic logic [14:0] cos_entry(input int k);
		longint unsigned x, x2, term;
		longint sum, q;
		x = (64'(k) * 64'd1686629713) / 64'(COS_TABLE_DEPTH - 1);
		x2 = (x * x) >> 30;
		term = 64'd1 << 30;
		sum = longint'(term);
		term = ((term * x2) >> 30) / 64'd2;
		sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd12;
		sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd30;
		sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd56;
		sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd90;
		sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd132;
		sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd182;
		sum = sum - longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		q = (sum + 64'sd16384) >>> 15;
		if (q > 32767) begin
			q = 32767;
		end
		return q[14:0];
	endfunction

	function automatic cos_tab_t build_cos_tab();
		cos_tab_t t;
		for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
			t[k] = cos_entry(k);
		end
		return t;
	endfunction

	localparam cos_tab_t COS_TAB = build_cos_tab();

	typedef enum logic [1:0] {ST_IDLE, ST_DISPATCH, ST_EVAL, ST_FIN} state_t;
	typedef enum logic [1:0] {PH_CAP, PH_MUL, PH_ACC} phase_t;
	typedef enum logic [1:0] {SH_0, SH_32, SH_64} shift_t;
	typedef enum logic [4:0] {
		SP_LATMUL, SP_RECIP, SP_AX, SP_BX, SP_AXSQ, SP_AYSQ, SP_BXSQ, SP_BYSQ,
		SP_DOTX, SP_DOTY, SP_LIMSQ, SP_T00, SP_T01, SP_T10, SP_T11,
		SP_R0, SP_R1, SP_R2, SP_L00, SP_L01, SP_L10, SP_L11, SP_DONE
	} step_t;

	// control state
	state_t state_q;
	phase_t phase_q;
	step_t step_q;
	logic [PRES_W-1:0] plim_q;
	logic signed [COS_W-1:0] clim_q;
	logic signed [LON_W-1:0] win_lon_q [2];
	logic signed [LAT_W-1:0] win_lat_q [2];
	logic [PRES_W-1:0] win_pres_q [2];
	logic [INDEX_BITS-1:0] line_start_q;
	logic [CNT_W-1:0] kept_q;
	logic [CNT_W-1:0] seen_q;
	logic need_a_q, need_b_q, sel_b_q, ok_b_q;
	logic out_valid_q;
	logic [INDEX_BITS-1:0] seg_start_q;
	logic [CNT_W-1:0] seg_count_q;

	// datapath
	logic signed [LON_W-1:0] cur_lon_q;
	logic signed [LAT_W-1:0] cur_lat_q;
	logic [PRES_W-1:0] cur_pres_q;
	logic [INDEX_BITS-1:0] cur_idx_q;
	logic cur_last_q;
	logic [13:0] amag_q;
	logic [LON_W:0] dla_mag_q, dlb_mag_q;
	logic dla_neg_q, dlb_neg_q;
	logic signed [20:0] la_q, lb_q;
	logic pres_ok_q;
	logic [17:0] m_q;
	logic [14:0] cos_q;
	logic signed [22:0] ax_q, bx_q;
	logic [44:0] na_q, nb_q, dm_q;
	logic signed [45:0] d_q;
	logic [30:0] l2_q;
	logic [89:0] t_q;
	logic [119:0] rhs_q;
	logic signed [PROD_W-1:0] mul_s1;
	logic signed [ACC_W-1:0] acc_q;

	// end vertex selection for the next test
	logic sel_nxt;
	logic signed [LON_W-1:0] p0_lon, p2_lon;
	logic signed [LAT_W-1:0] p0_lat, p2_lat;
	logic [PRES_W-1:0] p0_pres;
	logic signed [LON_W:0] dla, dlb;
	logic signed [LAT_W:0] dlat_a, dlat_b, lat1_ext;
	logic [LAT_W:0] lat1_abs;
	logic signed [PRES_W:0] dp;
	logic [PRES_W:0] dp_mag;

	always_comb begin
		sel_nxt = !need_a_q;
		p0_lon = sel_nxt ? cur_lon_q : win_lon_q[1];
		p2_lon = sel_nxt ? win_lon_q[1] : cur_lon_q;
		p0_lat = sel_nxt ? cur_lat_q : win_lat_q[1];
		p2_lat = sel_nxt ? win_lat_q[1] : cur_lat_q;
		p0_pres = sel_nxt ? cur_pres_q : win_pres_q[1];
		dla = (LON_W + 1)'(win_lon_q[0]) - (LON_W + 1)'(p0_lon);
		dlb = (LON_W + 1)'(p2_lon) - (LON_W + 1)'(win_lon_q[0]);
		dlat_a = (LAT_W + 1)'(win_lat_q[0]) - (LAT_W + 1)'(p0_lat);
		dlat_b = (LAT_W + 1)'(p2_lat) - (LAT_W + 1)'(win_lat_q[0]);
		lat1_ext = (LAT_W + 1)'(win_lat_q[0]);
		lat1_abs = lat1_ext[LAT_W] ? (LAT_W + 1)'(-lat1_ext) : (LAT_W + 1)'(lat1_ext);
		dp = $signed({1'b0, win_pres_q[0]}) - $signed({1'b0, p0_pres});
		dp_mag = dp[PRES_W] ? (PRES_W + 1)'(-dp) : (PRES_W + 1)'(dp);
	end

	// operand selection for the shared multiplier
	logic signed [MUL_W-1:0] op_a, op_b;
	logic acc_clr;
	shift_t acc_sh;

	always_comb begin
		op_a = '0;
		op_b = '0;
		acc_clr = 1'b0;
		acc_sh = SH_0;
		case (step_q)
			SP_LATMUL: begin
				op_a = MUL_W'(amag_q);
				op_b = MUL_W'(COS_TABLE_DEPTH - 1);
				acc_clr = 1'b1;
			end
			SP_RECIP: begin
				op_a = MUL_W'(m_q);
				op_b = MUL_W'(RECIP_45);
				acc_clr = 1'b1;
			end
			SP_AX: begin
				op_a = MUL_W'(dla_mag_q);
				op_b = MUL_W'(cos_q);
				acc_clr = 1'b1;
			end
			SP_BX: begin
				op_a = MUL_W'(dlb_mag_q);
				op_b = MUL_W'(cos_q);
				acc_clr = 1'b1;
			end
			SP_AXSQ: begin
				op_a = MUL_W'(ax_q);
				op_b = MUL_W'(ax_q);
				acc_clr = 1'b1;
			end
			SP_AYSQ: begin
				op_a = MUL_W'(la_q);
				op_b = MUL_W'(la_q);
			end
			SP_BXSQ: begin
				op_a = MUL_W'(bx_q);
				op_b = MUL_W'(bx_q);
				acc_clr = 1'b1;
			end
			SP_BYSQ: begin
				op_a = MUL_W'(lb_q);
				op_b = MUL_W'(lb_q);
			end
			SP_DOTX: begin
				op_a = MUL_W'(ax_q);
				op_b = MUL_W'(bx_q);
				acc_clr = 1'b1;
			end
			SP_DOTY: begin
				op_a = MUL_W'(la_q);
				op_b = MUL_W'(lb_q);
			end
			SP_LIMSQ: begin
				op_a = MUL_W'(clim_q);
				op_b = MUL_W'(clim_q);
				acc_clr = 1'b1;
			end
			SP_T00: begin
				op_a = MUL_W'(na_q[31:0]);
				op_b = MUL_W'(nb_q[31:0]);
				acc_clr = 1'b1;
			end
			SP_T01: begin
				op_a = MUL_W'(na_q[31:0]);
				op_b = MUL_W'(nb_q[44:32]);
				acc_sh = SH_32;
			end
			SP_T10: begin
				op_a = MUL_W'(na_q[44:32]);
				op_b = MUL_W'(nb_q[31:0]);
				acc_sh = SH_32;
			end
			SP_T11: begin
				op_a = MUL_W'(na_q[44:32]);
				op_b = MUL_W'(nb_q[44:32]);
				acc_sh = SH_64;
			end
			SP_R0: begin
				op_a = MUL_W'(t_q[31:0]);
				op_b = MUL_W'(l2_q);
				acc_clr = 1'b1;
			end
			SP_R1: begin
				op_a = MUL_W'(t_q[63:32]);
				op_b = MUL_W'(l2_q);
				acc_sh = SH_32;
			end
			SP_R2: begin
				op_a = MUL_W'(t_q[89:64]);
				op_b = MUL_W'(l2_q);
				acc_sh = SH_64;
			end
			SP_L00: begin
				op_a = MUL_W'(dm_q[31:0]);
				op_b = MUL_W'(dm_q[31:0]);
				acc_clr = 1'b1;
			end
			SP_L01: begin
				op_a = MUL_W'(dm_q[31:0]);
				op_b = MUL_W'(dm_q[44:32]);
				acc_sh = SH_32;
			end
			SP_L10: begin
				op_a = MUL_W'(dm_q[44:32]);
				op_b = MUL_W'(dm_q[31:0]);
				acc_sh = SH_32;
			end
			SP_L11: begin
				op_a = MUL_W'(dm_q[44:32]);
				op_b = MUL_W'(dm_q[44:32]);
				acc_sh = SH_64;
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	logic signed [ACC_W-1:0] prod_ext, prod_sh, acc_nxt;

	always_comb begin
		prod_ext = ACC_W'(mul_s1);
		case (acc_sh)
			SH_32: prod_sh = prod_ext << 32;
			SH_64: prod_sh = prod_ext << 64;
			default: prod_sh = prod_ext;
		endcase
		acc_nxt = (acc_clr ? ACC_W'(0) : acc_q) + prod_sh;
	end

	logic [33:0] x_rnd;
	logic signed [22:0] x_mag;

	always_comb begin
		x_rnd = acc_q[33:0] + 34'(X_ROUND);
		x_mag = {1'b0, x_rnd[X_SHIFT +: 22]};
	end

	// turn and pressure decision
	logic [119:0] lhs;
	logic lim_le0, vec_zero, d_neg, turn_ok, end_ok;

	always_comb begin
		lhs = {acc_q[89:0], {LIM_SHIFT{1'b0}}};
		lim_le0 = clim_q[COS_W-1] || (clim_q == '0);
		vec_zero = (na_q == '0) || (nb_q == '0);
		d_neg = d_q[45];
		if (vec_zero) begin
			turn_ok = lim_le0;
		end else if (!d_neg && lim_le0) begin
			turn_ok = 1'b1;
		end else if (d_neg && !lim_le0) begin
			turn_ok = 1'b0;
		end else if (!d_neg) begin
			turn_ok = lhs >= rhs_q;
		end else begin
			turn_ok = rhs_q >= lhs;
		end
		end_ok = pres_ok_q && turn_ok;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cur_lon_q <= lon;
			cur_lat_q <= lat;
			cur_pres_q <= pressure;
			cur_idx_q <= vertex_index;
			cur_last_q <= last_in_line;
		end
		if (state_q == ST_DISPATCH) begin
			amag_q <= (lat1_abs > (LAT_W + 1)'(LAT_SAT)) ? 14'(LAT_SAT) : lat1_abs[13:0];
			dla_neg_q <= dla[LON_W];
			dla_mag_q <= dla[LON_W] ? (LON_W + 1)'(-dla) : (LON_W + 1)'(dla);
			dlb_neg_q <= dlb[LON_W];
			dlb_mag_q <= dlb[LON_W] ? (LON_W + 1)'(-dlb) : (LON_W + 1)'(dlb);
			la_q <= 21'(dlat_a) << Y_SHIFT;
			lb_q <= 21'(dlat_b) << Y_SHIFT;
			pres_ok_q <= dp_mag <= (PRES_W + 1)'(plim_q);
		end
		if (state_q == ST_EVAL && phase_q == PH_MUL) begin
			mul_s1 <= op_a * op_b;
		end
		if (state_q == ST_EVAL && phase_q == PH_ACC) begin
			acc_q <= acc_nxt;
		end
		if (state_q == ST_EVAL && phase_q == PH_CAP) begin
			case (step_q)
				SP_RECIP: m_q <= 18'((acc_q[26:0] + 27'(LAT_HALF)) >> LAT_PRE_SHIFT);
				SP_AX: cos_q <= COS_TAB[acc_q[RECIP_SHIFT +: TAB_W]];
				SP_BX: ax_q <= dla_neg_q ? -x_mag : x_mag;
				SP_AXSQ: bx_q <= dlb_neg_q ? -x_mag : x_mag;
				SP_BXSQ: na_q <= acc_q[44:0];
				SP_DOTX: nb_q <= acc_q[44:0];
				SP_LIMSQ: d_q <= acc_q[45:0];
				SP_T00: begin
					l2_q <= acc_q[30:0];
					dm_q <= d_q[45] ? 45'(-d_q) : 45'(d_q);
				end
				SP_R0: t_q <= acc_q[89:0];
				SP_L00: rhs_q <= acc_q[119:0];
				default: begin
				end
			endcase
		end
	end

	// line bookkeeping at the end of a word
	logic [CNT_W-1:0] kept_inc, seen_inc, fin_count;
	logic seen_is0, seen_is1, fin_emit, fin_stall;

	always_comb begin
		kept_inc = (kept_q == CNT_MAX) ? kept_q : kept_q + 1'b1;
		seen_inc = (seen_q == CNT_MAX) ? seen_q : seen_q + 1'b1;
		seen_is0 = seen_q == '0;
		seen_is1 = seen_q == CNT_W'(1);
		fin_emit = 1'b0;
		fin_count = kept_q;
		if (seen_is0) begin
			fin_emit = 1'b0;
		end else if (seen_is1) begin
			fin_emit = cur_last_q;
			fin_count = CNT_W'(SHORT_LINE_COUNT);
		end else if (!cur_last_q) begin
			fin_count = kept_inc;
		end else if (ok_b_q) begin
			fin_count = kept_inc;
			fin_emit = kept_inc > CNT_W'(1);
		end else begin
			fin_emit = kept_q != '0;
		end
		fin_stall = fin_emit && out_valid_q && !out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_CAP;
			step_q <= SP_LATMUL;
			plim_q <= PRESSURE_LIMIT_RST;
			clim_q <= COS_LIMIT_RST;
			win_lon_q[0] <= '0;
			win_lon_q[1] <= '0;
			win_lat_q[0] <= '0;
			win_lat_q[1] <= '0;
			win_pres_q[0] <= '0;
			win_pres_q[1] <= '0;
			line_start_q <= '0;
			kept_q <= '0;
			seen_q <= '0;
			need_a_q <= 1'b0;
			need_b_q <= 1'b0;
			sel_b_q <= 1'b0;
			ok_b_q <= 1'b0;
			out_valid_q <= 1'b0;
			seg_start_q <= '0;
			seg_count_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_PRESSURE_LIMIT: plim_q <= cfg_data[PRES_W-1:0];
					CFG_COS_ANGLE_LIMIT: clim_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == ST_FIN && !fin_stall && fin_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						need_a_q <= seen_q == CNT_W'(SHORT_LINE_COUNT);
						need_b_q <= last_in_line && (seen_q >= CNT_W'(SHORT_LINE_COUNT));
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					if (need_a_q || need_b_q) begin
						sel_b_q <= !need_a_q;
						step_q <= SP_LATMUL;
						phase_q <= PH_CAP;
						state_q <= ST_EVAL;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_EVAL: begin
					case (phase_q)
						PH_CAP: begin
							if (step_q == SP_DONE) begin
								if (!sel_b_q) begin
									kept_q <= end_ok ? CNT_W'(2) : CNT_W'(1);
									if (!end_ok) begin
										line_start_q <= line_start_q + 1'b1;
									end
									need_a_q <= 1'b0;
								end else begin
									ok_b_q <= end_ok;
									need_b_q <= 1'b0;
								end
								state_q <= ST_DISPATCH;
							end else begin
								phase_q <= PH_MUL;
							end
						end
						PH_MUL: phase_q <= PH_ACC;
						PH_ACC: begin
							step_q <= step_t'(step_q + 1'b1);
							phase_q <= PH_CAP;
						end
						default: phase_q <= PH_CAP;
					endcase
				end
				ST_FIN: begin
					if (!fin_stall) begin
						if (fin_emit) begin
							seg_start_q <= line_start_q;
							seg_count_q <= fin_count;
						end
						if (seen_is0) begin
							line_start_q <= cur_idx_q;
						end
						if (cur_last_q || seen_is0) begin
							kept_q <= '0;
						end else if (!seen_is1) begin
							kept_q <= kept_inc;
						end
						seen_q <= cur_last_q ? '0 : seen_inc;
						win_lon_q[1] <= win_lon_q[0];
						win_lat_q[1] <= win_lat_q[0];
						win_pres_q[1] <= win_pres_q[0];
						win_lon_q[0] <= cur_lon_q;
						win_lat_q[0] <= cur_lat_q;
						win_pres_q[0] <= cur_pres_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign in_ready = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign seg_start = seg_start_q;
	assign seg_count = seg_count_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while a word is in progress");

	a_kept_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= seen_q)
		else $error("kept count exceeds vertices seen");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (seg_count != '0))
		else $error("empty segment emitted");

endmodule
`default_nettype wire

// ===== bench/tesf_checker.sv =====
// checker for the trajectory end segment filter: predicts segments and compares them
`timescale 1ns / 100ps
module tesf_checker
	import tesf_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [COS_W-1:0]         cfg_data,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic signed [LON_W-1:0]  lon,
	input  logic signed [LAT_W-1:0]  lat,
	input  logic [PRES_W-1:0]        pressure,
	input  logic [19:0]              vertex_index,
	input  logic                     last_in_line,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic [19:0]              seg_start,
	input  logic [CNT_W-1:0]         seg_count,
	output int                       fail_count,
	output int                       pending,
	output int                       segs_seen
);

	typedef struct packed {
		logic [19:0]      start;
		logic [CNT_W-1:0] count;
	} segment_t;

	segment_t expected_segs[$];
	logic [PRES_W-1:0] pres_limit;
	logic signed [COS_W-1:0] turn_limit;
	longint win_lon[2], win_lat[2], win_pres[2];
	logic [19:0] first_idx;
	longint kept, seen;
	longint cos_lut[256];

	assign pending = expected_segs.size();

	function automatic longint cos_value(longint k);
		longint unsigned x, x2, term;
		longint sum, q;
		x = k * 64'd1686629713 / 255;
		x2 = (x * x) >> 30;
		term = 64'd1 << 30;
		sum = term;
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
			if (n % 2) sum -= term; else sum += term;
		end
		if (sum < 0) sum = 0;
		q = (sum + 16384) >>> 15;
		return q > 32767 ? 32767 : q;
	endfunction

	function automatic longint lat_cosine(longint la);
		longint a;
		a = la < 0 ? -la : la;
		if (a > LAT_SAT) a = LAT_SAT;
		return cos_lut[(a * 255 + LAT_HALF) / LAT_SAT];
	endfunction

	function automatic longint scale_lon(longint d, longint c);
		longint r;
		r = ((d < 0 ? -d : d) * c + X_ROUND) >>> X_SHIFT;
		return d < 0 ? -r : r;
	endfunction

	function automatic bit turn_passes(longint ax, longint ay, longint bx, longint by);
		longint lim, na, nb, d, dm;
		logic [127:0] w, lhs, rhs;
		lim = turn_limit;
		na = ax * ax + ay * ay;
		nb = bx * bx + by * by;
		d = ax * bx + ay * by;
		if (na == 0 || nb == 0) return lim <= 0;
		if (d >= 0 && lim <= 0) return 1;
		if (d < 0 && lim > 0) return 0;
		dm = d < 0 ? -d : d;
		w = dm;
		lhs = (w * w) << LIM_SHIFT;
		w = na;
		rhs = w * 128'(nb) * 128'(lim * lim);
		return d >= 0 ? lhs >= rhs : rhs >= lhs;
	endfunction

	// v0 end vertex, v1 its neighbour, v2 next one inward
	function automatic bit end_passes(longint lo0, la0, pr0, lo1, la1, pr1, lo2, la2);
		longint dp, c;
		dp = pr1 - pr0;
		if (dp < 0) dp = -dp;
		if (dp > pres_limit) return 0;
		c = lat_cosine(la1);
		return turn_passes(scale_lon(lo1 - lo0, c), (la1 - la0) * 32,
			scale_lon(lo2 - lo1, c), (la2 - la1) * 32);
	endfunction

	function automatic longint sat_inc(longint v);
		return v >= CNT_MAX ? CNT_MAX : v + 1;
	endfunction

	task automatic queue_segment(logic [19:0] start, logic [CNT_W-1:0] count);
		segment_t s;
		s.start = start;
		s.count = count;
		expected_segs = {expected_segs, s};
	endtask

	task automatic predict_vertex(longint lo, longint la, longint pr, logic [19:0] idx,
		bit last);
		bit emit;
		emit = 0;
		if (seen == 0) begin
			first_idx = idx;
			kept = 0;
		end else if (seen == 1) begin
			if (last) begin
				queue_segment(first_idx, CNT_W'(SHORT_LINE_COUNT));
			end
		end else begin
			if (seen == 2) begin
				if (end_passes(win_lon[1], win_lat[1], win_pres[1], win_lon[0], win_lat[0],
						win_pres[0], lo, la)) begin
					kept = 1;
				end else begin
					kept = 0;
					first_idx = first_idx + 1'b1;
				end
				kept = sat_inc(kept);
			end
			if (!last) begin
				kept = sat_inc(kept);
			end else if (end_passes(lo, la, pr, win_lon[0], win_lat[0], win_pres[0],
					win_lon[1], win_lat[1])) begin
				kept = sat_inc(kept);
				emit = kept > 1;
			end else begin
				emit = kept > 0;
			end
			if (emit) queue_segment(first_idx, CNT_W'(kept));
		end
		win_lon[1] = win_lon[0]; win_lat[1] = win_lat[0]; win_pres[1] = win_pres[0];
		win_lon[0] = lo; win_lat[0] = la; win_pres[0] = pr;
		if (last) begin
			seen = 0;
			kept = 0;
		end else begin
			seen = sat_inc(seen);
		end
	endtask

	task automatic report(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	initial begin
		for (int k = 0; k < 256; k++) cos_lut[k] = cos_value(k);
	end

	always @(posedge clk or negedge arst_n) begin
		segment_t want;
		if (!arst_n) begin
			expected_segs.delete();
			pres_limit = PRESSURE_LIMIT_RST;
			turn_limit = COS_LIMIT_RST;
			win_lon = '{0, 0}; win_lat = '{0, 0}; win_pres = '{0, 0};
			first_idx = 0;
			kept = 0;
			seen = 0;
			fail_count = 0;
			segs_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PRESSURE_LIMIT: pres_limit = cfg_data[PRES_W-1:0];
					CFG_COS_ANGLE_LIMIT: turn_limit = cfg_data;
					default: begin
					end
				endcase
			end
			if (out_valid && out_ready) begin
				segs_seen++;
				if (expected_segs.size() == 0) begin
					report($sformatf("unexpected segment start %0d count %0d",
						seg_start, seg_count));
				end else begin
					want = expected_segs.pop_front();
					if (seg_start !== want.start)
						report($sformatf("seg_start %0d, want %0d", seg_start, want.start));
					if (seg_count !== want.count)
						report($sformatf("seg_count %0d, want %0d", seg_count, want.count));
				end
			end
			if (in_valid && in_ready)
				predict_vertex(lon, lat, pressure, vertex_index, last_in_line);
		end
	end

endmodule

// ===== bench/testbench.sv =====
// top of the trajectory end segment filter testbench: stimulus, watchdog and verdict
`timescale 1ns / 100ps
module testbench;
	import tesf_pkg::*;

	localparam int STALL_LIMIT = 6000;
	localparam int SETTLE = 400;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COS_W-1:0] cfg_data;
	logic in_valid, in_ready;
	logic signed [LON_W-1:0] lon;
	logic signed [LAT_W-1:0] lat;
	logic [PRES_W-1:0] pressure;
	logic [19:0] vertex_index;
	logic last_in_line;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [19:0] seg_start;
	logic [CNT_W-1:0] seg_count;
	int fail_count, pending, segs_seen;
	int send_idle, recv_stall, vertices_sent, lines_sent;
	int quiet_cycles = 0;
	logic [19:0] next_idx;

	trajectory_end_segment_filter dut (.*);

	tesf_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COS_W-1:0] value);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	task automatic send_vertex(longint lo, longint la, longint pr, logic [19:0] idx, bit last);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid <= 1;
		lon <= LON_W'(lo);
		lat <= LAT_W'(la);
		pressure <= PRES_W'(pr);
		vertex_index <= idx;
		last_in_line <= last;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		vertices_sent++;
		if (last) lines_sent++;
	endtask

	task automatic settle();
		in_valid <= 0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// a line of smooth steps, sometimes with kinks, big pressure jumps or raw noise
	task automatic random_line();
		int len, pick;
		longint lo, la, pr, dlo, dla;
		pick = $urandom_range(99);
		len = pick < 10 ? 1 : pick < 80 ? $urandom_range(2, 8) : $urandom_range(9, 20);
		if ($urandom_range(9) == 0) next_idx = 20'($urandom);
		lo = $signed($urandom_range(92160)) - 46080;
		la = $signed($urandom_range(23040)) - 11520;
		pr = $urandom_range(32767);
		dlo = $signed($urandom_range(600)) - 300;
		dla = $signed($urandom_range(600)) - 300;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(19) == 0) begin
				send_vertex($signed(17'($urandom)), $signed(15'($urandom)), $urandom_range(32767),
					next_idx, i == len - 1);
			end else begin
				if ($urandom_range(3) == 0) begin
					dlo = $signed($urandom_range(600)) - 300;
					dla = $signed($urandom_range(600)) - 300;
				end
				lo += dlo + $signed($urandom_range(20)) - 10;
				la += dla + $signed($urandom_range(20)) - 10;
				pr += $urandom_range(3) == 0 ? $signed($urandom_range(4000)) - 2000
					: $signed($urandom_range(200)) - 100;
				if (pr < 0) pr = 0;
				if (pr > 32767) pr = 32767;
				send_vertex(lo, la, pr, next_idx, i == len - 1);
			end
			next_idx = next_idx + 1'b1;
		end
	endtask

	task automatic directed_lines();
		send_vertex(5, 5, 100, 0, 1);
		send_vertex(-46080, -11520, 0, 10, 0);
		send_vertex(46080, 11520, 32767, 11, 1);
		send_vertex(0, 0, 100, 20, 0);
		send_vertex(100, 100, 110, 21, 0);
		send_vertex(200, 200, 120, 22, 1);
		send_vertex(0, 0, 0, 30, 0);
		send_vertex(100, 0, 32767, 31, 0);
		send_vertex(200, 0, 0, 32, 1);
		send_vertex(65535, 16383, 50, 40, 0);
		send_vertex(65535, 16383, 50, 41, 0);
		send_vertex(-65536, -16384, 50, 42, 0);
		send_vertex(-65536, -16384, 50, 43, 1);
		send_vertex(-46000, 16383, 200, 20'hffffe, 0);
		send_vertex(46000, 16383, 200, 20'hfffff, 0);
		send_vertex(-46000, 16383, 200, 20'h00000, 0);
		send_vertex(-46100, 16383, 200, 20'h00001, 1);
		for (int i = 0; i < 6; i++) send_vertex(i * 50, i * 40, 1000 + i, 20'(60 + i), i == 5);
		next_idx = 100;
	endtask

	task automatic run_phase(int s_idle, int r_stall, logic [PRES_W-1:0] plim,
		logic [COS_W-1:0] clim, int lines);
		settle();
		write_reg(CFG_PRESSURE_LIMIT, COS_W'(plim));
		write_reg(CFG_COS_ANGLE_LIMIT, clim);
		cfg_valid <= 0;
		send_idle = s_idle;
		recv_stall = r_stall;
		for (int i = 0; i < lines; i++) random_line();
	endtask

	initial begin
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		lon = '0;
		lat = '0;
		pressure = '0;
		vertex_index = '0;
		last_in_line = 0;
		send_idle = 0;
		recv_stall = 0;
		vertices_sent = 0;
		lines_sent = 0;
		next_idx = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed_lines();
		run_phase(0, 0, 800, 16'sd0, 24);
		run_phase(60, 0, 0, 16'h8000, 24);
		run_phase(0, 60, 15'h7fff, 16'h7fff, 24);
		run_phase(16, 16, PRES_W'($urandom_range(3000)), 16'sd23170, 24);
		run_phase(0, 0, PRES_W'($urandom), COS_W'($urandom), 24);
		settle();
		$display("sent %0d vertices in %0d lines over five limit settings", vertices_sent,
			lines_sent);
		$display("checked %0d segments", segs_seen);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
